// File: sv/heightmap_box_smoothing_assert.svh
// Assertion macros used by the heightmap smoothing checker.
// No dependencies; include by bare file name.
`ifndef HEIGHTMAP_BOX_SMOOTHING_ASSERT_SVH
`define HEIGHTMAP_BOX_SMOOTHING_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hbs_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the heightmap box smoothing block.
// No dependencies.
package hbs_pkg;

  // Operation codes of an input word
  localparam logic OpSample = 1'b0;
  localparam logic OpFlush  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [10:0] FrameWidthRst  = 11'd256;
  localparam logic [15:0] FrameHeightRst = 16'd256;

  // Quotient path: (sum << 8) needs 20 bits; x/3 == (x * 0xAAAAB) >> 21 for x < 2^20
  localparam int unsigned QuoW = 20;
  localparam logic [QuoW-1:0] Div3Mul = 20'hAAAAB;
  localparam int unsigned Div3Shift = 21;

  typedef struct packed {
    logic       operation;
    logic [7:0] sample;
  } hbs_in_t;

  typedef struct packed {
    logic [15:0] smoothed_height;
    logic        frame_last;
  } hbs_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StWin,
    StDiv
  } hbs_state_e;

endpackage

// File: sv/heightmap_box_smoothing.sv
`timescale 1ns / 1ps
// 3x3 box-mean smoothing of a raster heightmap stream, with two line memories.
// Depends on hbs_pkg.
//
// Usage:
//   Input words (in_valid_i / in_stall_o) carry an operation and an 8-bit sample in
//   raster order. A word moves when valid is high and stall is low. Flush words
//   move the stream past the last sample so the final row drains; a flush that
//   arrives while samples are still expected is taken and dropped.
//   Output words (out_valid_o / out_stall_i) carry the in-frame 3x3 mean as
//   unsigned 8.8 (truncated) and a flag on the frame's final position.
//   The result for position p leaves on the input word with stream index
//   p + width + 1; words before that produce nothing.
//   Processing: a word with a result goes through the memory read, the window
//   update, zero to two divide-by-3 multiply steps (count 9 needs two, counts 3
//   and 6 one), then the load into the output register; the input stays
//   stalled until that load. A word with no result ends after the window
//   update, and a dropped flush leaves the block idle.
//   The output register holds a finished word, so the block takes the next input
//   while that word waits; the divider stalls only while the register holds a
//   word that the receiver is stalling.
//   Configuration writes (cfg_valid_i / cfg_ready_o) are taken between words and
//   hold off the input while offered; width and height writes restart the frame.
//   Reset restores 256 x 256 and an empty window; the line memories are not
//   cleared, their stale entries only feed out-of-frame taps.
module heightmap_box_smoothing #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  hbs_pkg::hbs_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output hbs_pkg::hbs_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hbs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hbs_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);      // column index bits
  localparam int WW = $clog2(MAX_WIDTH + 1);  // width value bits
  localparam int PW = WW + 16;                // frame size product bits

  // Configuration and frame position
  logic [10:0]    fw_q;
  logic [15:0]    fh_q;
  logic [WW-1:0]  eff_w;
  logic [15:0]    eff_h;
  logic [PW-1:0]  prod_q;
  logic [CW-1:0]  in_col_q;
  logic [15:0]    in_row_q;
  logic [25:0]    out_pos_q;

  // Line memories and their read data
  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];
  logic [7:0] up_rd_q, mid_rd_q;

  // Window, [column: 0 oldest][row: 0 top]
  logic [2:0][2:0][7:0] win_q, win_new;

  // Per-word context, captured at accept; last flag and quotient at the window update
  logic [7:0] v_q;
  logic       emit_q, last_q;
  logic [2:0] cok_q, rok_q;
  logic [1:0] shift_q, n3_q;
  logic [hbs_pkg::QuoW-1:0] quo_q;

  hbs_pkg::hbs_state_e state_q, state_d;
  hbs_pkg::hbs_out_t   out_q;
  logic                out_valid_q;

  logic in_acc, in_frame, drop, cfg_we, out_free, out_load, last_c;
  logic emit_c, cok0, cok2, rok0, rok2;
  logic [CW-1:0] cc;
  logic [15:0]   cr;
  logic [11:0]   sum;
  logic [2*hbs_pkg::QuoW-1:0] div3_prod;

  // Effective frame size
  always_comb begin
    if (fw_q == 11'd0) begin
      eff_w = WW'(1);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_q);
    end
    eff_h = (fh_q == 16'd0) ? 16'd1 : fh_q;
  end

  // Frame size in positions; registered, so it settles the cycle after a register write
  always_ff @(posedge clk_i) begin
    prod_q <= PW'(eff_w) * PW'(eff_h);
  end

  // A pending register write takes priority over the input
  assign in_stall_o  = (state_q != hbs_pkg::StIdle) || cfg_valid_i;
  assign cfg_ready_o = (state_q == hbs_pkg::StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_frame    = (in_row_q < eff_h);
  assign drop        = in_frame && (in_data_i.operation == hbs_pkg::OpFlush);

  // Center of the window that the current word completes
  always_comb begin
    emit_c = (in_row_q >= 16'd2) || ((in_row_q == 16'd1) && (in_col_q != '0));
    if (in_col_q != '0) begin
      cc = in_col_q - CW'(1);
      cr = in_row_q - 16'd1;
    end else begin
      cc = CW'(eff_w - WW'(1));
      cr = in_row_q - 16'd2;
    end
    cok0 = (cc != '0);
    cok2 = ((WW'(cc) + WW'(1)) < eff_w);
    rok0 = (cr != 16'd0);
    rok2 = (({1'b0, cr} + 17'd1) < {1'b0, eff_h});
  end

  // Shift in the new column and sum the in-frame taps
  always_comb begin
    win_new[0] = win_q[1];
    win_new[1] = win_q[2];
    win_new[2] = {v_q, mid_rd_q, up_rd_q};
    sum = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (cok_q[c] && rok_q[r]) begin
          sum = sum + 12'(win_new[c][r]);
        end
      end
    end
  end

  assign last_c    = emit_q && ((32'(out_pos_q) + 32'd1) == 32'(prod_q));
  assign div3_prod = quo_q * hbs_pkg::Div3Mul;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_load  = (state_q == hbs_pkg::StDiv) && (n3_q == 2'd0) && out_free;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      hbs_pkg::StIdle: begin
        if (in_acc && !drop) begin
          state_d = hbs_pkg::StWin;
        end
      end
      hbs_pkg::StWin: begin
        state_d = emit_q ? hbs_pkg::StDiv : hbs_pkg::StIdle;
      end
      hbs_pkg::StDiv: begin
        if (out_load) begin
          state_d = hbs_pkg::StIdle;
        end
      end
      default: state_d = hbs_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Line memories: read at accept, write back during the window update
  always_ff @(posedge clk_i) begin
    if (in_acc && !drop) begin
      up_rd_q  <= upper_mem[in_col_q];
      mid_rd_q <= middle_mem[in_col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hbs_pkg::StWin) begin
      upper_mem[in_col_q]  <= mid_rd_q;
      middle_mem[in_col_q] <= v_q;
    end
  end

  // Word context and quotient path
  always_ff @(posedge clk_i) begin
    if (in_acc && !drop) begin
      v_q     <= in_frame ? in_data_i.sample : 8'd0;
      emit_q  <= emit_c;
      cok_q   <= {cok2, 1'b1, cok0};
      rok_q   <= {rok2, 1'b1, rok0};
      shift_q <= {1'b0, cok0 ^ cok2} + {1'b0, rok0 ^ rok2};
      n3_q    <= {1'b0, cok0 & cok2} + {1'b0, rok0 & rok2};
    end else if (state_q == hbs_pkg::StWin) begin
      quo_q  <= {sum, 8'd0} >> shift_q;
      last_q <= last_c;
    end else if ((state_q == hbs_pkg::StDiv) && (n3_q != 2'd0)) begin
      quo_q <= hbs_pkg::QuoW'(div3_prod >> hbs_pkg::Div3Shift);
      n3_q  <= n3_q - 2'd1;
    end
  end

  // Configuration, stream position and window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= hbs_pkg::FrameWidthRst;
      fh_q      <= hbs_pkg::FrameHeightRst;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_pos_q <= '0;
      win_q     <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == hbs_pkg::CfgFrameWidth) begin
        fw_q <= cfg_data_i[10:0];
      end
      if ((cfg_index_i == hbs_pkg::CfgFrameWidth) ||
          (cfg_index_i == hbs_pkg::CfgFrameHeight)) begin
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_pos_q <= '0;
        win_q     <= '0;
      end
      if (cfg_index_i == hbs_pkg::CfgFrameHeight) begin
        fh_q <= cfg_data_i;
      end
    end else if (state_q == hbs_pkg::StWin) begin
      if (last_c) begin
        // frame done: next sample starts a new frame
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_pos_q <= '0;
        win_q     <= '0;
      end else begin
        win_q <= win_new;
        if (emit_q) begin
          out_pos_q <= out_pos_q + 26'd1;
        end
        if ((WW'(in_col_q) + WW'(1)) >= eff_w) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 16'd1;
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.smoothed_height <= quo_q[15:0];
      out_q.frame_last      <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/heightmap_box_smoothing_chk.sv
`timescale 1ns / 1ps
// Port-level checker for heightmap_box_smoothing, attached by bind.
// Depends on hbs_pkg and heightmap_box_smoothing_assert.svh.
`include "heightmap_box_smoothing_assert.svh"

module heightmap_box_smoothing_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input hbs_pkg::hbs_in_t             in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input hbs_pkg::hbs_out_t            out_data_o
);

  logic sample_acc;
  assign sample_acc = in_valid_i && !in_stall_o &&
                      (in_data_i.operation == hbs_pkg::OpSample);

  `HBS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output word dropped while stalled")
  `HBS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o), "stalled output word changed")
  `HBS_ASSERT_IMPLIES(a_mean_range, clk_i, rst_ni, out_valid_o, out_data_o.smoothed_height <= 16'hFF00, "mean above 255.0")
  `HBS_ASSERT_NEXT(a_sample_busy, clk_i, rst_ni, sample_acc, in_stall_o, "sample word not processed")

endmodule

bind heightmap_box_smoothing heightmap_box_smoothing_chk u_chk (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for heightmap_box_smoothing: in-frame 3x3 mean of a raster stream.
// Depends on hbs_pkg and the heightmap_box_smoothing RTL; holds its own line-store predictor.
module tb_top;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned DrainLimit   = 50000;
  localparam int unsigned CycleLimit   = 400000;

  // Indexes with no register behind them; the block ignores writes to them.
  localparam logic [hbs_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [hbs_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  hbs_pkg::hbs_in_t             in_word = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  hbs_pkg::hbs_out_t            out_word;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [hbs_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [hbs_pkg::CfgDataW-1:0] cfg_data = '0;

  // Stimulus pacing: sender gap and receiver stall, in percent per cycle.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;     // long receiver hold-off, counted down by the stall process

  // Predictor copy of the block: registers, line stores, window and stream position.
  logic [10:0] cfg_width = hbs_pkg::FrameWidthRst;
  logic [15:0] cfg_height = hbs_pkg::FrameHeightRst;
  logic [7:0]  upper_mem [MaxWidth];
  logic [7:0]  middle_mem [MaxWidth];
  logic [7:0]  win [3][3];        // [column: 0 oldest][row: 0 top]
  int unsigned col_pos = 0;
  logic [15:0] row_pos = '0;
  logic [25:0] out_pos = '0;

  hbs_pkg::hbs_out_t smooth_q [$];   // predicted results, oldest first
  hbs_pkg::hbs_out_t due_word;

  int unsigned err_count = 0;
  int unsigned words_taken = 0;
  int unsigned flushes_dropped = 0;
  int unsigned results_checked = 0;
  int unsigned frames_done = 0;
  int unsigned cycle_count = 0;

  heightmap_box_smoothing #(
    .MAX_WIDTH(MaxWidth)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_word),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, smooth_q.size());
      $display("heightmap_box_smoothing verification failed");
      $finish;
    end
  end

  // Receiver: random stall, or a solid hold-off while hold_left runs down.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Register write or frame end: window and stream position clear, line stores stay.
  task automatic restart_frame();
    int unsigned i, j;
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++)
        win[i][j] = 8'd0;
    col_pos = 0;
    row_pos = '0;
    out_pos = '0;
  endtask

  // Advance the predictor by one accepted word; queue the mean it produces, if any.
  task automatic smooth_word(input hbs_pkg::hbs_in_t word);
    int unsigned w, h, c, cc, cr, sum, cnt, i, j;
    logic [7:0]  v;
    logic [2:0]  row_in, col_in;
    logic        last;
    hbs_pkg::hbs_out_t res;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MaxWidth) ? MaxWidth : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    last = 1'b0;
    // flush while samples are still owed: dropped, nothing moves
    if (row_pos < h && word.operation == hbs_pkg::OpFlush) begin
      flushes_dropped++;
      return;
    end
    // past the last sample every word is a flush tick feeding zero
    v = (row_pos < h) ? word.sample : 8'd0;
    c = (col_pos >= MaxWidth) ? MaxWidth - 1 : col_pos;
    for (i = 0; i < 2; i++)
      for (j = 0; j < 3; j++)
        win[i][j] = win[i + 1][j];
    win[2][0] = upper_mem[c];
    win[2][1] = middle_mem[c];
    win[2][2] = v;
    upper_mem[c] = middle_mem[c];
    middle_mem[c] = v;

    // window center trails the stream by one row plus one sample
    if ((row_pos >= 2) || (row_pos == 1 && col_pos >= 1)) begin
      if (col_pos > 0) begin
        cc = col_pos - 1;
        cr = row_pos - 1;
      end else begin
        cc = w - 1;
        cr = row_pos - 2;
      end
      row_in = {(cr + 1) < h, 1'b1, cr > 0};
      col_in = {(cc + 1) < w, 1'b1, cc > 0};
      sum = 0;
      cnt = 0;
      for (i = 0; i < 3; i++)
        for (j = 0; j < 3; j++)
          if (col_in[i] && row_in[j]) begin
            sum += win[i][j];
            cnt++;
          end
      last = (out_pos == 26'(w * h - 1));
      res.smoothed_height = 16'((sum << 8) / cnt);
      res.frame_last = last;
      smooth_q = {smooth_q, res};
      out_pos = out_pos + 26'd1;
    end

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 16'd1;
    end else begin
      col_pos++;
    end
    if (last) begin
      frames_done++;
      restart_frame();
    end
  endtask

  // Monitor: register writes and input words feed the predictor, output words are checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hbs_pkg::CfgFrameWidth: begin
            cfg_width = cfg_data[10:0];
            restart_frame();
          end
          hbs_pkg::CfgFrameHeight: begin
            cfg_height = cfg_data;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        words_taken++;
        smooth_word(in_word);
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (smooth_q.size() == 0) begin
          $error("unexpected result: smoothed_height %0d frame_last %0d",
                 out_word.smoothed_height, out_word.frame_last);
          err_count++;
        end else begin
          due_word = smooth_q.pop_front();
          if (out_word.smoothed_height !== due_word.smoothed_height) begin
            $error("smoothed_height expected %0d got %0d",
                   due_word.smoothed_height, out_word.smoothed_height);
            err_count++;
          end
          if (out_word.frame_last !== due_word.frame_last) begin
            $error("frame_last expected %0d got %0d",
                   due_word.frame_last, out_word.frame_last);
            err_count++;
          end
        end
      end
    end
  end

  // Offer one word, after a random gap; valid stays up so back-to-back words need no toggle.
  task automatic send_word(input logic op, input logic [7:0] smp);
    hbs_pkg::hbs_in_t word;
    word.operation = op;
    word.sample = smp;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  // Wait out every pending result, then the block's own latency for words with no result.
  task automatic wait_idle();
    int unsigned n;
    @(posedge clk);
    n = 0;
    while (smooth_q.size() != 0 && n < DrainLimit) begin
      @(posedge clk);
      n++;
    end
    if (smooth_q.size() != 0) begin
      $error("%0d expected results never arrived", smooth_q.size());
      err_count++;
      smooth_q.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [hbs_pkg::CfgIdxW-1:0] idx,
                           input logic [hbs_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset frame size (256 x 256): a row and a bit, enough for the first few means.
  task automatic test_reset_size();
    int unsigned k;
    for (k = 0; k < 260; k++)
      send_word(hbs_pkg::OpSample, 8'($urandom));
    end_burst();
    wait_idle();
  endtask

  // 3 x 2 frame: every corner and edge, dropped flush, sample past the end, frame end.
  task automatic test_corners();
    write_reg(hbs_pkg::CfgFrameWidth, 16'd3);
    write_reg(hbs_pkg::CfgFrameHeight, 16'd2);
    send_word(hbs_pkg::OpSample, 8'd255);
    send_word(hbs_pkg::OpFlush, 8'hFF);    // mid-frame, dropped
    send_word(hbs_pkg::OpSample, 8'd0);
    send_word(hbs_pkg::OpSample, 8'd255);
    send_word(hbs_pkg::OpSample, 8'd0);
    send_word(hbs_pkg::OpSample, 8'd255);
    send_word(hbs_pkg::OpSample, 8'd0);
    send_word(hbs_pkg::OpSample, 8'hA5);   // past the last sample: acts as a flush tick
    send_word(hbs_pkg::OpFlush, 8'h00);
    send_word(hbs_pkg::OpFlush, 8'h5A);
    send_word(hbs_pkg::OpFlush, 8'h00);    // final position, frame restarts
    send_word(hbs_pkg::OpFlush, 8'hC3);    // new frame, nothing owed yet: dropped
    send_word(hbs_pkg::OpSample, 8'd255);
    send_word(hbs_pkg::OpSample, 8'd255);
    end_burst();
    wait_idle();
  endtask

  // Width 0 and height 0 both act as 1; high width bits are ignored; spare indexes do nothing.
  task automatic test_degenerate_config();
    write_reg(hbs_pkg::CfgFrameWidth, 16'hF800);
    write_reg(hbs_pkg::CfgFrameHeight, 16'h0000);
    send_word(hbs_pkg::OpSample, 8'd255);
    send_word(hbs_pkg::OpFlush, 8'h00);
    send_word(hbs_pkg::OpSample, 8'h3C);
    end_burst();
    wait_idle();
    write_reg(CfgSpareA, 16'd5);
    write_reg(CfgSpareB, 16'd7);
    send_word(hbs_pkg::OpSample, 8'd128);
    send_word(hbs_pkg::OpFlush, 8'h00);
    send_word(hbs_pkg::OpFlush, 8'hFF);
    end_burst();
    wait_idle();
  endtask

  // Tallest frame: only its head is run, the next register write abandons it.
  task automatic test_tall_frame();
    write_reg(hbs_pkg::CfgFrameWidth, 16'd2);
    write_reg(hbs_pkg::CfgFrameHeight, 16'hFFFF);
    send_word(hbs_pkg::OpSample, 8'd17);
    send_word(hbs_pkg::OpSample, 8'd255);
    send_word(hbs_pkg::OpSample, 8'd0);
    send_word(hbs_pkg::OpSample, 8'd201);
    end_burst();
    wait_idle();
  endtask

  // Width above the line-store depth clamps to 1024; one full row plus a few samples.
  task automatic test_wide_row();
    int unsigned k;
    gap_pct = 14;
    stall_pct <= 14;
    end_burst();
    wait_idle();
    write_reg(hbs_pkg::CfgFrameWidth, 16'hFFFF);
    write_reg(hbs_pkg::CfgFrameHeight, 16'd3);
    for (k = 0; k < MaxWidth + 6; k++)
      send_word(hbs_pkg::OpSample, 8'($urandom));
    end_burst();
    wait_idle();
  endtask

  // Mostly whole small frames with random content and drain; some cut short, some noise flushes.
  task automatic test_random_frames(input int unsigned quota, input int unsigned gap,
                                    input int unsigned stall);
    int unsigned sent, w_eff, h_eff, span, cut, k;
    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic        reuse, broken;
    gap_pct = gap;
    stall_pct <= stall;
    sent = 0;
    reuse = 1'b0;
    width_reg = '0;
    height_reg = '0;
    while (sent < quota) begin
      if (!reuse) begin
        end_burst();
        wait_idle();
        case ($urandom_range(9))
          0:       width_reg = 11'd0;
          1:       width_reg = 11'($urandom_range(9, 16));
          default: width_reg = 11'($urandom_range(1, 6));
        endcase
        case ($urandom_range(9))
          0:       height_reg = 16'd0;
          1:       height_reg = 16'hFFFF;
          default: height_reg = 16'($urandom_range(1, 5));
        endcase
        write_reg(hbs_pkg::CfgFrameWidth, {5'($urandom), width_reg});
        write_reg(hbs_pkg::CfgFrameHeight, height_reg);
      end
      w_eff = (width_reg == 0) ? 1 : width_reg;
      h_eff = (height_reg == 0) ? 1 : height_reg;
      span = w_eff * h_eff;
      broken = (height_reg == 16'hFFFF) || ($urandom_range(9) == 0);
      if (height_reg == 16'hFFFF)
        cut = $urandom_range(1, 3 * w_eff);
      else if (broken)
        cut = $urandom_range(1, span);
      else
        cut = span;
      for (k = 0; k < cut; k++) begin
        if ($urandom_range(11) == 0)
          send_word(hbs_pkg::OpFlush, 8'($urandom));    // owed samples pending: dropped
        send_word(hbs_pkg::OpSample, 8'($urandom));
      end
      sent += cut;
      if (!broken) begin
        // drain: one row plus one word, each either a flush or a stray sample
        for (k = 0; k <= w_eff; k++)
          send_word($urandom_range(1) ? hbs_pkg::OpFlush : hbs_pkg::OpSample,
                    8'($urandom));
        sent += w_eff + 1;
        if ($urandom_range(4) == 0)
          send_word(hbs_pkg::OpFlush, 8'($urandom));    // at a fresh frame: dropped
        reuse = 1'($urandom_range(1));
      end else begin
        reuse = 1'b0;
      end
    end
    end_burst();
    wait_idle();
  endtask

  // Receiver holds off long enough for the block to fill and stall the sender.
  task automatic test_backpressure();
    int unsigned k;
    gap_pct = 0;
    stall_pct <= 0;
    write_reg(hbs_pkg::CfgFrameWidth, 16'd5);
    write_reg(hbs_pkg::CfgFrameHeight, 16'd4);
    hold_left <= 300;
    for (k = 0; k < 20; k++)
      send_word(hbs_pkg::OpSample, 8'($urandom));
    for (k = 0; k < 6; k++)
      send_word(hbs_pkg::OpFlush, 8'($urandom));
    end_burst();
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_corners();
    test_degenerate_config();
    test_tall_frame();
    test_random_frames(110, 0, 0);
    test_random_frames(110, 70, 0);
    test_wide_row();
    test_random_frames(110, 0, 70);
    test_random_frames(110, 14, 14);
    test_backpressure();

    end_burst();
    wait_idle();
    $display("Run took %0d input words (%0d flushes dropped) and checked %0d results,",
             words_taken, flushes_dropped, results_checked);
    $display("over %0d whole frames plus cut-short ones, widths 1 to 1024.", frames_done);
    if (err_count == 0)
      $display("heightmap_box_smoothing verification clean");
    else
      $display("heightmap_box_smoothing verification failed");
    $finish;
  end

endmodule
